### hdl/mags_pkg.sv
// Package for the mean aggregate gradient scatter unit.
// Holds payload structs, command and op codes, back-end states, scale width.
// No dependencies.
package mags_pkg;

	typedef enum logic [2:0] {
		CMD_LOAD_GRAD  = 3'd0,
		CMD_LOAD_DEG   = 3'd1,
		CMD_EDGE       = 3'd2,
		CMD_READ_ACC   = 3'd3,
		CMD_WRITE_ACC  = 3'd4
	} cmd_code_t;

	typedef struct packed {
		logic [2:0]         cmd;
		logic [9:0]         node;
		logic [9:0]         target_node;
		logic [5:0]         feature;
		logic signed [31:0] value;
		logic [15:0]        degree;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic               saturated;
	} out_item_t;

	// Classified operations handed from the front to the back.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD_GRAD,
		OP_LOAD_DEG,
		OP_EDGE,
		OP_READ_ACC,
		OP_WRITE_ACC
	} op_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_EDGE,
		BK_READ,
		BK_OUT
	} bk_state_t;

	localparam int SCALE_W = 17;

endpackage

### hdl/mean_aggregate_gradient_scatter_unit.sv
// Top level of the mean aggregate gradient scatter unit.
// Depends on mags_pkg, mags_front and mags_back.
//
// Usage: input transactions (in_valid/in_ready, in_data) carry commands to load a
// gradient element, load a degree, process an edge, or read or write an
// accumulator element. Every command gives exactly one output transaction
// (out_valid/out_ready, out_data). flow_direction is written with cfg_we/cfg_data.
// The front end classifies and queues up to two commands; the back end executes
// one command at a time from its memories.
// A degree load runs the reciprocal divider, one quotient bit a cycle, and an
// edge passes one feature a cycle through the read, multiply and accumulate
// pipeline. The back end takes no new command until an edge has written back
// every feature and its result has been taken.
// After reset the accumulator is cleared by a pass over every address, during
// which no input is taken; configuration writes are accepted meanwhile.
// If the receiver stalls, the result is held and the queue fills, after which
// in_ready falls.
module mean_aggregate_gradient_scatter_unit import mags_pkg::*; #(
	parameter int NODES = 1024,
	parameter int DIM = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic      cfg_data
);

	localparam int NW = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int FW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int AW = NW + FW;

	logic flow_q;
	logic q_valid, q_ready;
	op_t  q_op;
	logic [NW-1:0] q_node, q_to;
	logic [FW-1:0] q_feat;
	logic [31:0] q_value;
	logic [15:0] q_degree;
	logic clearing;
	logic fr_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) flow_q <= 1'b0;
		else if (cfg_we) flow_q <= cfg_data;
	end

	assign in_ready = fr_ready && !clearing;

	mags_front #(.NODES(NODES), .DIM(DIM), .NW(NW), .FW(FW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid && !clearing),
		.in_ready(fr_ready), .in_data(in_data), .flow_direction(flow_q),
		.q_valid(q_valid), .q_ready(q_ready), .q_op(q_op), .q_node(q_node),
		.q_to(q_to), .q_feat(q_feat), .q_value(q_value), .q_degree(q_degree)
	);

	mags_back #(.NODES(NODES), .DIM(DIM), .NW(NW), .FW(FW), .AW(AW)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready),
		.q_op(q_op), .q_node(q_node), .q_to(q_to), .q_feat(q_feat),
		.q_value(q_value), .q_degree(q_degree), .out_valid(out_valid),
		.out_ready(out_ready), .out_data(out_data), .clearing(clearing)
	);

endmodule

### hdl/mags_front.sv
// Front end: accepts input transactions and classifies them into queue entries.
// Depends on mags_pkg. The entry queue is a small register FIFO.
module mags_front import mags_pkg::*; #(
	parameter int NODES = 1024,
	parameter int DIM = 64,
	parameter int NW = 10,
	parameter int FW = 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  in_item_t        in_data,
	input  logic            flow_direction,
	output logic            q_valid,
	input  logic            q_ready,
	output op_t             q_op,
	output logic [NW-1:0]   q_node,
	output logic [NW-1:0]   q_to,
	output logic [FW-1:0]   q_feat,
	output logic [31:0]     q_value,
	output logic [15:0]     q_degree
);

	typedef struct packed {
		op_t            op;
		logic [NW-1:0]  node;
		logic [NW-1:0]  to;
		logic [FW-1:0]  feat;
		logic [31:0]    value;
		logic [15:0]    degree;
	} entry_t;

	entry_t ent_q [2];
	logic   wp_q, rp_q;
	logic [1:0] cnt_q;
	entry_t e;
	logic node_ok, tnode_ok, feat_ok;
	logic push, pop;

	always_comb begin
		node_ok  = 32'(in_data.node) < NODES;
		tnode_ok = 32'(in_data.target_node) < NODES;
		feat_ok  = 32'(in_data.feature) < DIM;
		e.node   = NW'(in_data.node);
		e.to     = NW'(in_data.target_node);
		e.feat   = FW'(in_data.feature);
		e.value  = in_data.value;
		e.degree = in_data.degree;
		e.op     = OP_NOP;
		unique case (in_data.cmd)
			CMD_LOAD_GRAD: if (node_ok && feat_ok) e.op = OP_LOAD_GRAD;
			CMD_LOAD_DEG:  if (node_ok) e.op = OP_LOAD_DEG;
			CMD_EDGE: begin
				if (node_ok && tnode_ok) e.op = OP_EDGE;
				// Edge: node field carries the source row, to the destination row.
				e.node = flow_direction ? NW'(in_data.node) : NW'(in_data.target_node);
				e.to   = flow_direction ? NW'(in_data.target_node) : NW'(in_data.node);
			end
			CMD_READ_ACC:  if (node_ok && feat_ok) e.op = OP_READ_ACC;
			CMD_WRITE_ACC: if (node_ok && feat_ok) e.op = OP_WRITE_ACC;
			default:       e.op = OP_NOP;
		endcase
	end

	assign in_ready = cnt_q != 2'd2;
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != 2'd0;
	assign pop = q_valid && q_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) ent_q[wp_q] <= e;
	end

	assign q_op = ent_q[rp_q].op;
	assign q_node = ent_q[rp_q].node;
	assign q_to = ent_q[rp_q].to;
	assign q_feat = ent_q[rp_q].feat;
	assign q_value = ent_q[rp_q].value;
	assign q_degree = ent_q[rp_q].degree;

endmodule

### hdl/mags_recip.sv
// Iterative restoring divider that forms floor(65536 / degree) one bit a cycle.
// Depends on mags_pkg for the scale width.
module mags_recip import mags_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [15:0]        degree,
	output logic               done,
	output logic [SCALE_W-1:0] scale
);

	logic [16:0] rem_q;
	logic [16:0] quo_q;
	logic [15:0] div_q;
	logic [4:0]  step_q;
	logic        busy_q;
	logic [17:0] trial;
	logic [17:0] shifted;

	// Dividend is 2^16: a single one shifted in on the first step only.
	assign shifted = {rem_q, (step_q == 5'd0)};
	assign trial = shifted - {2'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 5'd1;
				if (step_q == 5'd16) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= '0;
			div_q <= degree;
		end else if (busy_q) begin
			if (!trial[17]) begin
				rem_q <= trial[16:0];
				quo_q <= {quo_q[15:0], 1'b1};
			end else begin
				rem_q <= shifted[16:0];
				quo_q <= {quo_q[15:0], 1'b0};
			end
		end
	end

	assign scale = (div_q == 16'd0) ? '0 : quo_q;

endmodule

### hdl/mags_back.sv
// Back end: owns the gradient, scale and accumulator memories and executes entries.
// Depends on mags_pkg and mags_recip.
module mags_back import mags_pkg::*; #(
	parameter int NODES = 1024,
	parameter int DIM = 64,
	parameter int NW = 10,
	parameter int FW = 6,
	parameter int AW = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	output logic          q_ready,
	input  op_t           q_op,
	input  logic [NW-1:0] q_node,
	input  logic [NW-1:0] q_to,
	input  logic [FW-1:0] q_feat,
	input  logic [31:0]   q_value,
	input  logic [15:0]   q_degree,
	output logic          out_valid,
	input  logic          out_ready,
	output out_item_t     out_data,
	output logic          clearing
);

	localparam int DEPTH = NODES * DIM;

	logic [31:0]        grad_mem [DEPTH];
	logic [SCALE_W-1:0] scale_mem [NODES];
	logic [31:0]        acc_mem [DEPTH];

	bk_state_t state_q, state_d;
	op_t       op_q;
	logic [NW-1:0] node_q, to_q;
	logic [FW-1:0] feat_q;
	logic [15:0]   degree_q;
	logic [AW:0]   clr_q;
	logic          clr_busy;
	logic [FW:0]   rd_cnt_q;
	logic [FW:0]   wb_cnt_q;
	logic          rd_v_s1, mul_v_s2;
	logic [AW-1:0] rd_addr_s1, addr_s2;
	logic [31:0]   grad_s1, acc_s1;
	logic [SCALE_W-1:0] scale_q;
	logic signed [48:0] prod_s2;
	logic [31:0]   acc_s2;
	logic          sat_q;
	logic [31:0]   rdv_q;
	logic          rd_pend_s1;
	logic          div_start, div_done;
	logic [SCALE_W-1:0] div_scale;
	logic signed [33:0] sum;
	logic [31:0]   sum_sat;
	logic          sum_clip;
	logic          take;

	assign clr_busy = !clr_q[AW];
	assign clearing = clr_busy;

	mags_recip u_recip (
		.clk(clk), .arst_n(arst_n), .start(div_start), .degree(degree_q),
		.done(div_done), .scale(div_scale)
	);

	assign q_ready = (state_q == BK_IDLE) && !clr_busy;
	assign take = q_valid && q_ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE: if (take) begin
				unique case (q_op)
					OP_LOAD_DEG: state_d = BK_DIV;
					OP_EDGE:     state_d = BK_EDGE;
					OP_READ_ACC: state_d = BK_READ;
					default:     state_d = BK_OUT;
				endcase
			end
			BK_DIV:  if (div_done) state_d = BK_OUT;
			BK_EDGE: if (wb_cnt_q == (FW+1)'(DIM)) state_d = BK_OUT;
			BK_READ: if (rd_pend_s1) state_d = BK_OUT;
			BK_OUT:  if (out_ready) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// Outputs.
	always_comb begin
		out_valid = state_q == BK_OUT;
		out_data.read_value = (op_q == OP_READ_ACC) ? rdv_q : '0;
		out_data.saturated = (op_q == OP_EDGE) ? sat_q : 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			clr_q <= '0;
			div_start <= 1'b0;
			rd_v_s1 <= 1'b0;
			mul_v_s2 <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (clr_busy) clr_q <= clr_q + 1'b1;
			div_start <= take && (q_op == OP_LOAD_DEG);
			rd_v_s1 <= (state_q == BK_EDGE) && (rd_cnt_q < (FW+1)'(DIM));
			mul_v_s2 <= rd_v_s1;
			rd_pend_s1 <= take && (q_op == OP_READ_ACC);
		end
	end

	logic [AW-1:0] rd_addr;
	always_comb begin
		rd_addr = AW'(32'(node_q) * DIM + 32'(rd_cnt_q[FW-1:0]));
	end

	always_ff @(posedge clk) begin
		if (take) begin
			op_q <= q_op;
			node_q <= q_node;
			to_q <= q_to;
			feat_q <= q_feat;
			degree_q <= q_degree;
			rd_cnt_q <= '0;
			wb_cnt_q <= '0;
			sat_q <= 1'b0;
			if (q_op == OP_EDGE) scale_q <= scale_mem[q_node];
		end
		if (state_q == BK_EDGE && rd_cnt_q < (FW+1)'(DIM)) rd_cnt_q <= rd_cnt_q + 1'b1;
		// Stage 1: gradient and accumulator reads.
		rd_addr_s1 <= AW'(32'(to_q) * DIM + 32'(rd_cnt_q[FW-1:0]));
		grad_s1 <= grad_mem[rd_addr];
		acc_s1 <= acc_mem[AW'(32'(to_q) * DIM + 32'(rd_cnt_q[FW-1:0]))];
		// Stage 2: multiply; floor shift is an arithmetic shift.
		prod_s2 <= $signed(grad_s1) * $signed({1'b0, scale_q});
		acc_s2 <= acc_s1;
		addr_s2 <= rd_addr_s1;
		if (mul_v_s2) begin
			wb_cnt_q <= wb_cnt_q + 1'b1;
			if (sum_clip) sat_q <= 1'b1;
		end
		if (rd_pend_s1) rdv_q <= acc_mem[AW'(32'(node_q) * DIM + 32'(feat_q))];
	end

	always_comb begin
		sum = 34'($signed(acc_s2)) + 34'(prod_s2 >>> 16);
		sum_clip = sum[33] != sum[31] || sum[33] != sum[32];
		sum_sat = sum_clip ? (sum[33] ? 32'h8000_0000 : 32'h7fff_ffff) : sum[31:0];
	end

	// Single write port per memory; the clearing pass, edge write-back and direct
	// writes never coincide.
	always_ff @(posedge clk) begin
		if (clr_busy) acc_mem[clr_q[AW-1:0]] <= '0;
		else if (mul_v_s2) acc_mem[addr_s2] <= sum_sat;
		else if (take && q_op == OP_WRITE_ACC)
			acc_mem[AW'(32'(q_node) * DIM + 32'(q_feat))] <= q_value;
	end

	always_ff @(posedge clk) begin
		if (take && q_op == OP_LOAD_GRAD)
			grad_mem[AW'(32'(q_node) * DIM + 32'(q_feat))] <= q_value;
	end

	always_ff @(posedge clk) begin
		if (div_done) scale_mem[node_q] <= div_scale;
	end

endmodule

### hdl/mags_checker.sv
// Port-level checker for the mean aggregate gradient scatter unit, with its bind.
// Depends on mags_pkg.
module mags_port_checker import mags_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_data
);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input transaction changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	a_one_cycle_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("result repeated after transaction");

	a_read_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.saturated |-> out_data.read_value == '0)
		else $error("saturation flag on a read result");

endmodule

bind mean_aggregate_gradient_scatter_unit mags_port_checker u_mags_port_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.in_data(in_data), .out_valid(out_valid), .out_ready(out_ready),
	.out_data(out_data)
);
